// ===== sv/adaptive_first_order_lag_filter_macros.svh =====
// ----------------------------------------------------------------------------
// adaptive first-order lag filter assertion macros
// shared assertion shorthands for the filter rtl
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_FIRST_ORDER_LAG_FILTER_MACROS_SVH
`define ADAPTIVE_FIRST_ORDER_LAG_FILTER_MACROS_SVH

// same-cycle implication
`define AFLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aflf_pkg.sv =====
// ----------------------------------------------------------------------------
// aflf_pkg
// types and constants of the adaptive first-order lag filter
// ----------------------------------------------------------------------------
package aflf_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int VALUE_BITS    = SAMPLE_BITS + FRACTION_BITS;
  localparam int THR_BITS      = 16;
  localparam int CNT_BITS      = 4;
  localparam int COUNT_STEPS   = 1 << CNT_BITS;
  localparam int GAIN_BITS     = 8;
  localparam int WEIGHT_BITS   = 9;
  localparam int GPROD_BITS    = GAIN_BITS + CNT_BITS;
  localparam int PROD_BITS     = WEIGHT_BITS + VALUE_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [WEIGHT_BITS-1:0] FULL_WEIGHT  = WEIGHT_BITS'(256);
  localparam logic [CNT_BITS:0]      EXTRA_COUNTS = (CNT_BITS + 1)'(2);

  localparam logic [THR_BITS-1:0]    THR_RESET   = THR_BITS'(10);
  localparam logic [CNT_BITS-1:0]    LIMIT_RESET = CNT_BITS'(12);
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET  = GAIN_BITS'(20);
  localparam logic [WEIGHT_BITS-1:0] REV_RESET   = WEIGHT_BITS'(5);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP_THRESHOLD  = 2'd0,
    REG_COUNT_LIMIT     = 2'd1,
    REG_GAIN_PER_COUNT  = 2'd2,
    REG_REVERSAL_WEIGHT = 2'd3
  } cfg_reg_t;

  typedef logic [COUNT_STEPS-1:0][WEIGHT_BITS-1:0] weight_tab_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] filt;
    logic                  dir;
    logic [CNT_BITS-1:0]   run;
    logic                  primed;
  } aflf_state_t;

  typedef struct packed {
    logic [THR_BITS-1:0]    thr;
    logic [CNT_BITS-1:0]    limit;
    logic [WEIGHT_BITS-1:0] rev_w;
  } aflf_cfg_t;

  function automatic logic [WEIGHT_BITS-1:0] sat_gain(input logic [GPROD_BITS-1:0] p);
    logic [WEIGHT_BITS-1:0] r;
    r = (p > GPROD_BITS'(FULL_WEIGHT)) ? FULL_WEIGHT : p[WEIGHT_BITS-1:0];
    return r;
  endfunction

endpackage

// ===== sv/aflf_step.sv =====
// ----------------------------------------------------------------------------
// aflf_step
// one filter update: direction, run count, weight and lag step
// ----------------------------------------------------------------------------
module aflf_step (
  input  aflf_pkg::aflf_state_t                  cur,
  input  logic [aflf_pkg::SAMPLE_BITS-1:0]       sample,
  input  aflf_pkg::aflf_cfg_t                    cfg,
  input  aflf_pkg::weight_tab_t                  gain_tab,
  output aflf_pkg::aflf_state_t                  nxt,
  output logic [aflf_pkg::WEIGHT_BITS-1:0]       weight
);
  import aflf_pkg::*;

  logic [VALUE_BITS-1:0]  s_ext;
  logic                   dir;
  logic [VALUE_BITS-1:0]  mag;
  logic                   big;
  logic [CNT_BITS:0]      c_sum;
  logic [CNT_BITS-1:0]    c_new;
  logic [WEIGHT_BITS-1:0] rev_sat;
  logic [WEIGHT_BITS-1:0] w_step;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   prod_up;
  logic [VALUE_BITS-1:0]  delta;

  assign s_ext = {sample, FRACTION_BITS'(0)};
  assign dir   = !(cur.filt > s_ext);
  assign mag   = dir ? (s_ext - cur.filt) : (cur.filt - s_ext);
  assign big   = (mag >= {cfg.thr, FRACTION_BITS'(0)});

  always_comb begin
    c_sum = {1'b0, cur.run} + (CNT_BITS + 1)'(1) + (big ? EXTRA_COUNTS : '0);
    if (c_sum >= {1'b0, cfg.limit}) begin
      c_new = cfg.limit;
    end else begin
      c_new = c_sum[CNT_BITS-1:0];
    end
  end

  assign rev_sat = (cfg.rev_w > FULL_WEIGHT) ? FULL_WEIGHT : cfg.rev_w;
  assign w_step  = (dir == cur.dir) ? gain_tab[c_new] : rev_sat;

  // round toward minus infinity on falling steps
  assign prod    = PROD_BITS'(w_step) * PROD_BITS'(mag);
  assign prod_up = dir ? prod : (prod + PROD_BITS'(FULL_WEIGHT - 1'b1));
  assign delta   = prod_up[FRACTION_BITS +: VALUE_BITS];

  always_comb begin
    nxt = cur;
    if (!cur.primed) begin
      nxt.filt   = s_ext;
      nxt.primed = 1'b1;
      weight     = FULL_WEIGHT;
    end else begin
      nxt.filt = dir ? (cur.filt + delta) : (cur.filt - delta);
      nxt.dir  = dir;
      nxt.run  = (dir == cur.dir) ? c_new : '0;
      weight   = w_step;
    end
  end

endmodule

// ===== sv/adaptive_first_order_lag_filter.sv =====
// ----------------------------------------------------------------------------
// adaptive_first_order_lag_filter
// lag filter whose weight follows the same-direction run of the samples
// ----------------------------------------------------------------------------
// Takes one item per clock while out_stall and configuration writes allow;
// the item is registered in the input register, the update runs through one
// subtract, one 9x24 multiply and one add between that register and the
// result register, and the new filtered value feeds back in the same cycle.
// A configuration write holds the input register while the registered
// table of gain times count is refreshed. The result register lets a new
// item be accepted while a finished result is still stalled.
// ----------------------------------------------------------------------------
`include "adaptive_first_order_lag_filter_macros.svh"

module adaptive_first_order_lag_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [aflf_pkg::SAMPLE_BITS-1:0]     in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [aflf_pkg::VALUE_BITS-1:0]      out_filtered,
  output logic [aflf_pkg::WEIGHT_BITS-1:0]     out_weight_used,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aflf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [aflf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import aflf_pkg::*;

  aflf_cfg_t              cfg_r;
  logic [GAIN_BITS-1:0]   gain_r;
  weight_tab_t            gain_tab_r;
  logic                   cfg_pend_r;
  logic                   cfg_fire;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   adv;
  logic                   in_fire;

  aflf_state_t            st_r;
  aflf_state_t            st_nxt;
  logic [WEIGHT_BITS-1:0] weight_nxt;
  logic                   out_valid_r;
  logic [WEIGHT_BITS-1:0] out_weight_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr   <= THR_RESET;
      cfg_r.limit <= LIMIT_RESET;
      cfg_r.rev_w <= REV_RESET;
      gain_r      <= GAIN_RESET;
      cfg_pend_r  <= 1'b1;
    end else begin
      cfg_pend_r <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STEP_THRESHOLD:  cfg_r.thr   <= cfg_wdata[THR_BITS-1:0];
          REG_COUNT_LIMIT:     cfg_r.limit <= cfg_wdata[CNT_BITS-1:0];
          REG_GAIN_PER_COUNT:  gain_r      <= cfg_wdata[GAIN_BITS-1:0];
          REG_REVERSAL_WEIGHT: cfg_r.rev_w <= cfg_wdata[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // saturated gain times count, one entry per count value
  always_ff @(posedge clk) begin
    for (int g = 0; g < COUNT_STEPS; g++) begin
      gain_tab_r[g] <= sat_gain(GPROD_BITS'(gain_r) * GPROD_BITS'(g));
    end
  end

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall) && !cfg_pend_r;
  assign in_stall = s1_valid_r && !adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
    end
  end

  aflf_step u_step (
    .cur      (st_r),
    .sample   (s1_sample_r),
    .cfg      (cfg_r),
    .gain_tab (gain_tab_r),
    .nxt      (st_nxt),
    .weight   (weight_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      st_r        <= st_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_weight_r <= weight_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_filtered    = st_r.filt;
  assign out_weight_used = out_weight_r;

  `AFLF_ASSERT_NEXT(a_cfg_holds_step, cfg_fire, !adv,
                    "item advanced on stale weight table")
  `AFLF_ASSERT_NEXT(a_first_full, adv && !st_r.primed,
                    out_weight_used == FULL_WEIGHT && st_r.primed,
                    "first item not loaded directly")
  `AFLF_ASSERT_NOW(a_unprimed_clear, !st_r.primed, st_r.run == '0 && !st_r.dir,
                   "run state moved before first item")
  `AFLF_ASSERT_NOW(a_weight_range, out_valid_r, out_weight_used <= FULL_WEIGHT,
                   "weight above full scale")

endmodule
